// File: sv/gwwlb_pkg.sv
// Shared types and constants for the greedy word-wrap line breaker.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package gwwlb_pkg;

	localparam int IDX_W   = 16;
	localparam int MAXW_W  = 12;
	localparam int CODE_W  = 8;
	localparam int GLYPH_W = 8;

	localparam logic [CODE_W-1:0] CODE_SPACE   = 8'd32;
	localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;

	// line queue: three lines per character at most, one spare entry
	localparam int                 SLOTS      = 3;
	localparam int                 FIFO_DEPTH = 4;
	localparam int                 FIFO_AW    = 2;
	localparam int                 FIFO_CW    = 3;
	localparam logic [FIFO_CW-1:0] FIFO_FULL  = 3'd4;

	typedef struct packed {
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] end_index;
		logic             final_line;
	} line_t;

	typedef struct packed {
		logic [1:0]           cnt;
		line_t [SLOTS-1:0]    line;
	} push_t;

endpackage

// File: sv/gwwlb_core.sv
// Line break decision and per-text state for the word-wrap line breaker.
// Depends on gwwlb_pkg; feeds up to three finished lines per character to the line queue.
`timescale 1ns / 1ps

module gwwlb_core #(
	parameter int LINE_LIMIT = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [gwwlb_pkg::MAXW_W-1:0] cfg_max_width,
	input  logic                         item_valid,
	input  logic [gwwlb_pkg::CODE_W-1:0] char_code,
	input  logic [gwwlb_pkg::GLYPH_W-1:0] glyph_width,
	input  logic                         text_end,
	input  logic [gwwlb_pkg::FIFO_CW-1:0] fifo_free,
	output logic                         item_take,
	output gwwlb_pkg::push_t             push
);

	localparam int LW = $clog2(LINE_LIMIT + 1);
	localparam logic [LW:0] LIMIT_EXT = (LW + 1)'(LINE_LIMIT);

	localparam int IW = gwwlb_pkg::IDX_W;

	logic [gwwlb_pkg::MAXW_W-1:0] max_width_q;
	logic [IW-1:0] line_begin_q, char_pos_q, width_sum_q, space_pos_q, wts_q;
	logic          space_seen_q;
	logic [LW-1:0] lines_out_q;

	logic [IW-1:0] pos, next_pos, nw, w_ext, rem, lb1;
	logic [IW:0]   nw_full;
	logic          is_nl, is_print, here_space, seen_eff, over;
	logic [IW-1:0] sp_eff, wts_eff, max_ext;
	logic [IW-1:0] lb_n, ws_n;
	logic          seen_n;
	logic          a_v, b_v, c_v;
	logic [IW-1:0] a_f, a_e, b_f, b_e, c_f, c_e;
	logic [1:0]    ncand, cnt;
	logic [LW:0]   room;

	always_comb begin
		pos        = char_pos_q;
		next_pos   = char_pos_q + 1'b1;
		is_nl      = (char_code == gwwlb_pkg::CODE_NEWLINE);
		is_print   = (char_code >= gwwlb_pkg::CODE_SPACE);
		w_ext      = IW'(glyph_width) + 1'b1;
		nw_full    = {1'b0, width_sum_q} + {1'b0, w_ext};
		nw         = nw_full[IW] ? '1 : nw_full[IW-1:0];
		max_ext    = IW'(max_width_q);
		here_space = (char_code == gwwlb_pkg::CODE_SPACE) && (pos != line_begin_q);
		sp_eff     = here_space ? pos : space_pos_q;
		wts_eff    = here_space ? nw : wts_q;
		seen_eff   = here_space | space_seen_q;
		over       = (max_width_q != '0) && (nw > max_ext);
		lb1        = sp_eff + 1'b1;
		rem        = nw - wts_eff;

		lb_n   = line_begin_q;
		ws_n   = width_sum_q;
		seen_n = space_seen_q;
		a_v = 1'b0; a_f = line_begin_q; a_e = pos;
		b_v = 1'b0; b_f = lb1;          b_e = pos;

		if (is_nl) begin
			a_v    = 1'b1;
			lb_n   = next_pos;
			ws_n   = '0;
			seen_n = 1'b0;
		end else if (is_print) begin
			seen_n = seen_eff;
			ws_n   = nw;
			if (over) begin
				if (seen_eff) begin
					// break at the last space and drop it
					a_v    = 1'b1;
					a_e    = sp_eff;
					lb_n   = lb1;
					seen_n = 1'b0;
					if (sp_eff == pos) begin
						ws_n = '0;
					end else begin
						ws_n = rem;
						if (rem > max_ext && pos != lb1) begin
							b_v  = 1'b1;
							lb_n = pos;
							ws_n = w_ext;
						end
					end
				end else if (pos != line_begin_q) begin
					a_v  = 1'b1;
					lb_n = pos;
					ws_n = w_ext;
				end
			end
		end

		c_v = text_end && !is_nl && (lb_n != next_pos);
		c_f = lb_n;
		c_e = next_pos;

		ncand = 2'({1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v});
		room  = LIMIT_EXT - {1'b0, lines_out_q};
		cnt   = (room < (LW + 1)'(ncand)) ? room[1:0] : ncand;

		item_take = item_valid && (gwwlb_pkg::FIFO_CW'(cnt) <= fifo_free);

		push.cnt = item_take ? cnt : 2'd0;
		push.line[0].first_index = a_v ? a_f : c_f;
		push.line[0].end_index   = a_v ? a_e : c_e;
		push.line[1].first_index = b_v ? b_f : c_f;
		push.line[1].end_index   = b_v ? b_e : c_e;
		push.line[2].first_index = c_f;
		push.line[2].end_index   = c_e;
		push.line[0].final_line  = text_end && (cnt == 2'd1);
		push.line[1].final_line  = text_end && (cnt == 2'd2);
		push.line[2].final_line  = text_end && (cnt == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_width_q <= '0;
		end else if (cfg_we) begin
			max_width_q <= cfg_max_width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_begin_q <= '0;
			char_pos_q   <= '0;
			width_sum_q  <= '0;
			space_pos_q  <= '0;
			space_seen_q <= 1'b0;
			wts_q        <= '0;
			lines_out_q  <= '0;
		end else if (item_take) begin
			if (text_end) begin
				// end of text: start the next one afresh
				line_begin_q <= '0;
				char_pos_q   <= '0;
				width_sum_q  <= '0;
				space_pos_q  <= '0;
				space_seen_q <= 1'b0;
				wts_q        <= '0;
				lines_out_q  <= '0;
			end else begin
				line_begin_q <= lb_n;
				char_pos_q   <= next_pos;
				width_sum_q  <= ws_n;
				space_pos_q  <= sp_eff;
				space_seen_q <= seen_n;
				wts_q        <= wts_eff;
				lines_out_q  <= lines_out_q + LW'(cnt);
			end
		end
	end

	a_lines_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(LW + 1)'(lines_out_q) <= LIMIT_EXT)
		else $error("line count beyond limit");

	a_text_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		item_take && text_end |=> lines_out_q == '0 && char_pos_q == '0)
		else $error("text state not cleared after last character");

endmodule

// File: sv/gwwlb_line_fifo.sv
// Small queue of finished lines; takes up to three per cycle, gives one per beat.
// Depends on gwwlb_pkg for the line record and queue sizes.
`timescale 1ns / 1ps

module gwwlb_line_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gwwlb_pkg::push_t              push,
	output logic [gwwlb_pkg::FIFO_CW-1:0] free,
	output logic                          out_valid,
	input  logic                          out_ready,
	output gwwlb_pkg::line_t              out_line
);

	gwwlb_pkg::line_t mem [gwwlb_pkg::FIFO_DEPTH];

	logic [gwwlb_pkg::FIFO_AW-1:0] rd_q, wr_q;
	logic [gwwlb_pkg::FIFO_CW-1:0] occ_q;
	logic                          pop;

	assign free      = gwwlb_pkg::FIFO_FULL - occ_q;
	assign out_valid = (occ_q != '0);
	assign out_line  = mem[rd_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		for (int i = 0; i < gwwlb_pkg::SLOTS; i++) begin
			if (2'(i) < push.cnt) begin
				mem[wr_q + gwwlb_pkg::FIFO_AW'(i)] <= push.line[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			occ_q <= '0;
		end else begin
			wr_q  <= wr_q + gwwlb_pkg::FIFO_AW'(push.cnt);
			rd_q  <= rd_q + gwwlb_pkg::FIFO_AW'(pop);
			occ_q <= occ_q + gwwlb_pkg::FIFO_CW'(push.cnt) - gwwlb_pkg::FIFO_CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		gwwlb_pkg::FIFO_CW'(push.cnt) <= free)
		else $error("line queue overflow");

	a_occ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= gwwlb_pkg::FIFO_FULL)
		else $error("line queue occupancy out of range");

endmodule

// File: sv/greedy_word_wrap_line_breaker.sv
// Greedy word-wrap line breaker: one text character per input beat, one line per output beat.
// Depends on gwwlb_pkg, gwwlb_core and gwwlb_line_fifo.
`timescale 1ns / 1ps

// Usage
//   s_axis carries one character per beat: code and glyph width in tdata, end of
//   text on tlast. m_axis carries one line per beat: first and end index in
//   tdata, the last line of a text marked on tlast. The cfg channel writes the
//   line width limit in pixels (zero turns wrapping off); write it only while
//   the block is idle.
//   Path: an accepted character passes the input register, then the line
//   queue, before its lines appear on m_axis.
//   Throughput: one character per cycle while each character ends at most one
//   line and the receiver keeps up. The line queue holds four lines and a
//   character is taken from the input register only when the queue has room
//   for all lines it ends, so a character that ends two or three lines may
//   hold the input while the queue drains.
//   A stalled receiver fills the line queue, then the input register, then
//   drops s_axis_tready; nothing is lost.
//   Reset clears the limit, the text state and the queue; no clearing pass.
module greedy_word_wrap_line_breaker #(
	parameter int LINE_LIMIT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] char_code, [15:8] glyph_width
	input  logic        s_axis_tlast,   // text_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [15:0] first_index, [31:16] end_index
	output logic        m_axis_tlast    // final_line
);

	logic       v_s1;
	logic [7:0] code_s1, glyph_s1;
	logic       last_s1;

	logic                          take;
	gwwlb_pkg::push_t              push;
	logic [gwwlb_pkg::FIFO_CW-1:0] free;
	gwwlb_pkg::line_t              head;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !v_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	// hold the beat until the core takes it
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			code_s1  <= s_axis_tdata[7:0];
			glyph_s1 <= s_axis_tdata[15:8];
			last_s1  <= s_axis_tlast;
		end
	end

	gwwlb_core #(
		.LINE_LIMIT(LINE_LIMIT)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_max_width(cfg_data),
		.item_valid   (v_s1),
		.char_code    (code_s1),
		.glyph_width  (glyph_s1),
		.text_end     (last_s1),
		.fifo_free    (free),
		.item_take    (take),
		.push         (push)
	);

	gwwlb_line_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.free     (free),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_line (head)
	);

	assign m_axis_tdata = {head.end_index, head.first_index};
	assign m_axis_tlast = head.final_line;

	a_take_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> v_s1)
		else $error("core took a character with none held");

endmodule
